/* rtl/min_jerk_trajectory_gen_defines.svh */
// Assertion macros shared by the trajectory generator RTL.
// Every macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MIN_JERK_TRAJECTORY_GEN_DEFINES_SVH
`define MIN_JERK_TRAJECTORY_GEN_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MJT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MJT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mjt_pkg.sv */
// Shared widths, types and the control-store program of the trajectory generator.
// No dependencies; used by mjt_core and min_jerk_trajectory_gen.
package mjt_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int TAU_FRAC  = 24;
  localparam int POS_W     = 32;
  localparam int NUM_AXES  = 3;
  localparam int AX_W      = 2;
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;

  // Datapath widths: A operand holds a 33-bit axis span, B a 30-bit polynomial
  localparam int ALPHA_W   = POS_W + 1;
  localparam int POLY_W    = 30;
  localparam int OPA_W     = ALPHA_W + 1;
  localparam int OPB_W     = POLY_W;
  localparam int PROD_W    = OPA_W + OPB_W;
  // floor(prod / 2^TAU_FRAC) is exactly as wide as a derivative output
  localparam int DERIV_W   = PROD_W - TAU_FRAC;
  localparam int POS_SUM_W = DERIV_W + 1;
  localparam int ACC_W     = 34;
  localparam int COEF_W    = 9;
  localparam int PC_W      = 5;
  localparam int CNT_W     = 5;
  localparam int DST_W     = 3;
  localparam int OUT_DATA_W = NUM_AXES * POS_W + 2 * NUM_AXES * DERIV_W;

  localparam logic [TIME_W-1:0] DUR_RESET = TIME_W'(5000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd6;

  // Polynomial coefficients
  localparam logic signed [COEF_W-1:0] K_NONE = 9'sd0;
  localparam logic signed [COEF_W-1:0] K_6    = 9'sd6;
  localparam logic signed [COEF_W-1:0] K_10   = 9'sd10;
  localparam logic signed [COEF_W-1:0] K_N15  = -9'sd15;
  localparam logic signed [COEF_W-1:0] K_30   = 9'sd30;
  localparam logic signed [COEF_W-1:0] K_60   = 9'sd60;
  localparam logic signed [COEF_W-1:0] K_N60  = -9'sd60;
  localparam logic signed [COEF_W-1:0] K_120  = 9'sd120;
  localparam logic signed [COEF_W-1:0] K_N180 = -9'sd180;

  // Write-back destinations
  localparam logic [DST_W-1:0] DST_NONE = 3'd0;
  localparam logic [DST_W-1:0] DST_T2   = 3'd2;
  localparam logic [DST_W-1:0] DST_T3   = 3'd3;
  localparam logic [DST_W-1:0] DST_T4   = 3'd4;
  localparam logic [DST_W-1:0] DST_T5   = 3'd5;
  localparam logic [DST_W-1:0] DST_SP   = 3'd0;
  localparam logic [DST_W-1:0] DST_SV   = 3'd1;
  localparam logic [DST_W-1:0] DST_SA   = 3'd2;
  localparam logic [DST_W-1:0] DST_X    = 3'd0;
  localparam logic [DST_W-1:0] DST_Y    = 3'd1;
  localparam logic [DST_W-1:0] DST_Z    = 3'd2;

  localparam logic [AX_W-1:0] AX_X = 2'd0;
  localparam logic [AX_W-1:0] AX_Y = 2'd1;
  localparam logic [AX_W-1:0] AX_Z = 2'd2;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [DERIV_W-1:0] deriv_t;
  typedef pos_t   [NUM_AXES-1:0]     pos3_t;
  typedef deriv_t [NUM_AXES-1:0]     deriv3_t;

  typedef struct packed {
    pos3_t   pos;
    deriv3_t vel;
    deriv3_t acc;
  } traj_res_t;

  // Sequencer control
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_DIV, SEQ_END} seq_op_t;
  typedef enum logic [2:0] {A_T1, A_T2, A_T3, A_T4, A_COEF, A_ALPHA} a_sel_t;
  typedef enum logic [2:0] {B_T1, B_T2, B_T3, B_T4, B_T5, B_SP, B_SV, B_SA} b_sel_t;
  typedef enum logic [2:0] {
    WB_NONE, WB_POW, WB_LD, WB_ADD, WB_POLY, WB_POS, WB_VEL, WB_ACC
  } wb_op_t;

  // One control word: the multiply issued this step, and the write-back of the
  // product issued in the step before
  typedef struct packed {
    seq_op_t                   seq;
    a_sel_t                    a_sel;
    b_sel_t                    b_sel;
    logic signed [COEF_W-1:0]  coef;
    logic [AX_W-1:0]           mul_axis;
    wb_op_t                    wb;
    logic [DST_W-1:0]          wb_dst;
  } ucode_t;

  function automatic ucode_t uword(seq_op_t s, a_sel_t a, b_sel_t b,
                                   logic signed [COEF_W-1:0] c, logic [AX_W-1:0] ax,
                                   wb_op_t w, logic [DST_W-1:0] d);
    ucode_t u;
    u.seq      = s;
    u.a_sel    = a;
    u.b_sel    = b;
    u.coef     = c;
    u.mul_axis = ax;
    u.wb       = w;
    u.wb_dst   = d;
    return u;
  endfunction

  // Control store: restoring divide, powers of tau, the three polynomials,
  // then nine axis products
  function automatic ucode_t ucode_fetch(logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      5'd0:  u = uword(SEQ_DIV,  A_T1,    B_T1, K_NONE, AX_X, WB_NONE, DST_NONE);
      5'd1:  u = uword(SEQ_NEXT, A_T1,    B_T1, K_NONE, AX_X, WB_NONE, DST_NONE);
      5'd2:  u = uword(SEQ_NEXT, A_COEF,  B_T1, K_60,   AX_X, WB_POW,  DST_T2);
      5'd3:  u = uword(SEQ_NEXT, A_T2,    B_T1, K_NONE, AX_X, WB_LD,   DST_NONE);
      5'd4:  u = uword(SEQ_NEXT, A_COEF,  B_T2, K_N180, AX_X, WB_POW,  DST_T3);
      5'd5:  u = uword(SEQ_NEXT, A_T3,    B_T1, K_NONE, AX_X, WB_ADD,  DST_NONE);
      5'd6:  u = uword(SEQ_NEXT, A_COEF,  B_T3, K_120,  AX_X, WB_POW,  DST_T4);
      5'd7:  u = uword(SEQ_NEXT, A_T4,    B_T1, K_NONE, AX_X, WB_POLY, DST_SA);
      5'd8:  u = uword(SEQ_NEXT, A_COEF,  B_T2, K_30,   AX_X, WB_POW,  DST_T5);
      5'd9:  u = uword(SEQ_NEXT, A_COEF,  B_T3, K_N60,  AX_X, WB_LD,   DST_NONE);
      5'd10: u = uword(SEQ_NEXT, A_COEF,  B_T4, K_30,   AX_X, WB_ADD,  DST_NONE);
      5'd11: u = uword(SEQ_NEXT, A_COEF,  B_T3, K_10,   AX_X, WB_POLY, DST_SV);
      5'd12: u = uword(SEQ_NEXT, A_COEF,  B_T4, K_N15,  AX_X, WB_LD,   DST_NONE);
      5'd13: u = uword(SEQ_NEXT, A_COEF,  B_T5, K_6,    AX_X, WB_ADD,  DST_NONE);
      5'd14: u = uword(SEQ_NEXT, A_ALPHA, B_SA, K_NONE, AX_X, WB_POLY, DST_SP);
      5'd15: u = uword(SEQ_NEXT, A_ALPHA, B_SA, K_NONE, AX_Y, WB_ACC,  DST_X);
      5'd16: u = uword(SEQ_NEXT, A_ALPHA, B_SA, K_NONE, AX_Z, WB_ACC,  DST_Y);
      5'd17: u = uword(SEQ_NEXT, A_ALPHA, B_SV, K_NONE, AX_X, WB_ACC,  DST_Z);
      5'd18: u = uword(SEQ_NEXT, A_ALPHA, B_SV, K_NONE, AX_Y, WB_VEL,  DST_X);
      5'd19: u = uword(SEQ_NEXT, A_ALPHA, B_SV, K_NONE, AX_Z, WB_VEL,  DST_Y);
      5'd20: u = uword(SEQ_NEXT, A_ALPHA, B_SP, K_NONE, AX_X, WB_VEL,  DST_Z);
      5'd21: u = uword(SEQ_NEXT, A_ALPHA, B_SP, K_NONE, AX_Y, WB_POS,  DST_X);
      5'd22: u = uword(SEQ_NEXT, A_ALPHA, B_SP, K_NONE, AX_Z, WB_POS,  DST_Y);
      5'd23: u = uword(SEQ_END,  A_T1,    B_T1, K_NONE, AX_X, WB_POS,  DST_Z);
      default: u = uword(SEQ_END, A_T1,   B_T1, K_NONE, AX_X, WB_NONE, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

/* rtl/mjt_core.sv */
// Microcoded datapath: restoring divider for tau, one shared signed multiplier,
// accumulator and result registers. Depends on mjt_pkg.
module mjt_core import mjt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [TIME_W-1:0] elapsed,
  input  logic [TIME_W-1:0] dur,
  input  pos3_t             start_pos,
  input  pos3_t             end_pos,
  output logic              done,
  output traj_res_t         res
);

  logic                      running;
  logic [PC_W-1:0]           pc;
  logic [CNT_W-1:0]          cnt;
  ucode_t                    uw;

  logic [TIME_W-1:0]         rem;
  logic [TAU_FRAC-1:0]       t1, t2, t3, t4, t5;
  logic signed [POLY_W-1:0]  sp, sv, sa;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ALPHA_W-1:0] alpha [NUM_AXES];
  pos3_t                     res_pos;
  deriv3_t                   res_vel, res_acc;

  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic [TIME_W:0]           rem2, den, rem_diff;
  logic                      q_bit;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [DERIV_W-1:0]        prod_hi;
  logic [AX_W-1:0]           wb_axis;
  pos_t                      wb_start;
  logic signed [POS_SUM_W-1:0] pos_sum;
  pos_t                      pos_sat;

  assign uw = ucode_fetch(pc);

  // Select multiplier operands
  always_comb begin
    case (uw.a_sel)
      A_T1:    op_a = {{(OPA_W-TAU_FRAC){1'b0}}, t1};
      A_T2:    op_a = {{(OPA_W-TAU_FRAC){1'b0}}, t2};
      A_T3:    op_a = {{(OPA_W-TAU_FRAC){1'b0}}, t3};
      A_T4:    op_a = {{(OPA_W-TAU_FRAC){1'b0}}, t4};
      A_COEF:  op_a = {{(OPA_W-COEF_W){uw.coef[COEF_W-1]}}, uw.coef};
      A_ALPHA: op_a = {alpha[uw.mul_axis][ALPHA_W-1], alpha[uw.mul_axis]};
      default: op_a = '0;
    endcase
    case (uw.b_sel)
      B_T1:    op_b = {{(OPB_W-TAU_FRAC){1'b0}}, t1};
      B_T2:    op_b = {{(OPB_W-TAU_FRAC){1'b0}}, t2};
      B_T3:    op_b = {{(OPB_W-TAU_FRAC){1'b0}}, t3};
      B_T4:    op_b = {{(OPB_W-TAU_FRAC){1'b0}}, t4};
      B_T5:    op_b = {{(OPB_W-TAU_FRAC){1'b0}}, t5};
      B_SP:    op_b = sp;
      B_SV:    op_b = sv;
      B_SA:    op_b = sa;
      default: op_b = '0;
    endcase
  end

  // One restoring division step: the remainder always stays below dur
  always_comb begin
    rem2     = {rem, 1'b0};
    den      = {1'b0, dur};
    q_bit    = (rem2 >= den);
    rem_diff = rem2 - den;
  end

  // Write-back arithmetic on the product of the previous step
  always_comb begin
    acc_sum  = acc + prod[ACC_W-1:0];
    prod_hi  = prod[PROD_W-1:TAU_FRAC];
    wb_axis  = uw.wb_dst[AX_W-1:0];
    wb_start = start_pos[wb_axis];
    pos_sum  = {{(POS_SUM_W-POS_W){wb_start[POS_W-1]}}, wb_start}
             + {prod_hi[DERIV_W-1], prod_hi};
    // Saturate to the position width
    if (&pos_sum[POS_SUM_W-1:POS_W-1] || ~|pos_sum[POS_SUM_W-1:POS_W-1]) begin
      pos_sat = pos_sum[POS_W-1:0];
    end else if (pos_sum[POS_SUM_W-1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // Sequencer: step counter with a self loop for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= '0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        pc      <= '0;
        cnt     <= '0;
      end else if (running) begin
        case (uw.seq)
          SEQ_DIV: begin
            if (cnt == CNT_W'(TAU_FRAC - 1)) begin
              pc <= pc + 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          SEQ_NEXT: pc <= pc + 1'b1;
          SEQ_END: begin
            running <= 1'b0;
            done    <= 1'b1;
          end
          default: running <= 1'b0;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= elapsed;
      t1  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        alpha[i] <= {end_pos[i][POS_W-1], end_pos[i]} - {start_pos[i][POS_W-1], start_pos[i]};
      end
    end else if (running) begin
      prod <= op_a * op_b;
      if (uw.seq == SEQ_DIV) begin
        rem <= q_bit ? rem_diff[TIME_W-1:0] : rem2[TIME_W-1:0];
        t1  <= {t1[TAU_FRAC-2:0], q_bit};
      end
      case (uw.wb)
        WB_POW: begin
          case (uw.wb_dst)
            DST_T2:  t2 <= prod[2*TAU_FRAC-1:TAU_FRAC];
            DST_T3:  t3 <= prod[2*TAU_FRAC-1:TAU_FRAC];
            DST_T4:  t4 <= prod[2*TAU_FRAC-1:TAU_FRAC];
            DST_T5:  t5 <= prod[2*TAU_FRAC-1:TAU_FRAC];
            default: ;
          endcase
        end
        WB_LD:  acc <= prod[ACC_W-1:0];
        WB_ADD: acc <= acc_sum;
        WB_POLY: begin
          case (uw.wb_dst)
            DST_SP:  sp <= acc_sum[POLY_W-1:0];
            DST_SV:  sv <= acc_sum[POLY_W-1:0];
            DST_SA:  sa <= acc_sum[POLY_W-1:0];
            default: ;
          endcase
        end
        WB_POS:  res_pos[wb_axis] <= pos_sat;
        WB_VEL:  res_vel[wb_axis] <= prod_hi;
        WB_ACC:  res_acc[wb_axis] <= prod_hi;
        default: ;
      endcase
    end
  end

  assign res.pos = res_pos;
  assign res.vel = res_vel;
  assign res.acc = res_acc;

endmodule

/* rtl/min_jerk_trajectory_gen.sv */
// Channel     | dir | tdata fields (low bit first)                     | tuser
// s (time)    | in  | time_now[31:0]                                   | -
// m (result)  | out | pos_x,pos_y,pos_z (32 each), vel_x..z, acc_x..z   | done_res
//                     (40 each), 336 bits                              |
// cfg         | in  | cfg_addr selects register 0..6, cfg_wdata 32 bits | -
// An item on the finished path is marked pending at its transaction and is then
// loaded into the output register; any other item passes 24 restoring-divider steps,
// 23 microcode steps on the shared 34x30 multiplier, the done handoff and the output load.
// The next item is taken once the previous result sits in the output register.
// Reset is synchronous; no clearing pass. A stalled output holds its result
// and blocks at most one further item in the core.
// Top level: handshake, configuration registers, start-time capture, output
// register. Depends on mjt_pkg, mjt_core and min_jerk_trajectory_gen_defines.svh.
`include "min_jerk_trajectory_gen_defines.svh"

module min_jerk_trajectory_gen import mjt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TIME_W-1:0]     s_tdata,    // time_now
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,    // pos_x,y,z, vel_x,y,z, acc_x,y,z
  output logic [0:0]            m_tuser,    // done_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [POS_W-1:0]      cfg_wdata
);

  pos3_t             start_pos, end_pos;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] start_time;
  logic              armed, finished;
  logic              busy, pend, src_fin, pend_done;

  logic              in_hs, cfg_hit, fin_hit, go, load, core_done;
  logic [TIME_W-1:0] base_time, elapsed;
  traj_res_t         core_res, out_res;

  assign in_hs     = s_tvalid && s_tready;
  assign s_tready  = !busy && !pend;
  assign cfg_hit   = cfg_we && (cfg_addr <= REG_DURATION);
  assign base_time = armed ? s_tdata : start_time;
  assign elapsed   = s_tdata - base_time;
  assign fin_hit   = (elapsed >= dur);
  assign go        = in_hs && !fin_hit;
  assign load      = pend && (!m_tvalid || m_tready);

  mjt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .elapsed   (elapsed),
    .dur       (dur),
    .start_pos (start_pos),
    .end_pos   (end_pos),
    .done      (core_done),
    .res       (core_res)
  );

  // Choose the end point or the evaluated polynomials
  always_comb begin
    if (src_fin) begin
      out_res.pos = end_pos;
      out_res.vel = '0;
      out_res.acc = '0;
    end else begin
      out_res = core_res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= '0;
      end_pos   <= '0;
      dur       <= DUR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_X:  start_pos[AX_X] <= cfg_wdata;
        REG_START_Y:  start_pos[AX_Y] <= cfg_wdata;
        REG_START_Z:  start_pos[AX_Z] <= cfg_wdata;
        REG_END_X:    end_pos[AX_X]   <= cfg_wdata;
        REG_END_Y:    end_pos[AX_Y]   <= cfg_wdata;
        REG_END_Z:    end_pos[AX_Z]   <= cfg_wdata;
        REG_DURATION: dur             <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Trajectory state and transaction control
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      armed      <= 1'b1;
      finished   <= 1'b0;
      busy       <= 1'b0;
      pend       <= 1'b0;
      src_fin    <= 1'b0;
      pend_done  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (in_hs) begin
        start_time <= base_time;
        armed      <= 1'b0;
        src_fin    <= fin_hit;
        pend_done  <= finished || fin_hit;
        if (fin_hit) begin
          finished <= 1'b1;
          pend     <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end
      if (core_done) begin
        busy <= 1'b0;
        pend <= 1'b1;
      end
      // Move a waiting result into the output register
      if (load) begin
        pend     <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // A register write re-arms
      if (cfg_hit) begin
        armed    <= 1'b1;
        finished <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {out_res.acc[AX_Z], out_res.acc[AX_Y], out_res.acc[AX_X],
                  out_res.vel[AX_Z], out_res.vel[AX_Y], out_res.vel[AX_X],
                  out_res.pos[AX_Z], out_res.pos[AX_Y], out_res.pos[AX_X]};
      m_tuser <= pend_done;
    end
  end

  `MJT_ASSERT_IMP(a_done_while_busy, core_done, busy, "core finished while idle")
  `MJT_ASSERT_NXT(a_accept_tracked, in_hs, busy || pend, "accepted item not tracked")
  `MJT_ASSERT_NXT(a_pend_held, pend && m_tvalid && !m_tready, pend, "waiting result lost")
  `MJT_ASSERT_NXT(a_cfg_rearm, cfg_hit, armed && !finished, "register write did not re-arm")

endmodule
